// ===== sv/fir_filter_circular_history_core_defines.svh =====
// assertion macros for the circular history fir filter checker
// depends on nothing; the including module provides clk_i and rst_ni
`ifndef FIR_FILTER_CIRCULAR_HISTORY_CORE_DEFINES_SVH
`define FIR_FILTER_CIRCULAR_HISTORY_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FIRCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FIRCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/firch_pkg.sv =====
// shared constants, types and codes of the circular history fir filter
// depends on nothing
package firch_pkg;

  // filter length and word widths
  localparam int TAPS    = 51;
  localparam int DATA_W  = 16;
  localparam int TSEL_W  = 6;
  localparam int IDX_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = PROD_W + IDX_W + 1;
  localparam int FRAC_SH = DATA_W - 1;

  // input word operation codes
  typedef enum logic [0:0] {
    OP_FILTER = 1'b0,
    OP_COEF   = 1'b1
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND
  } state_e;

  // sequencer to datapath control
  typedef struct packed {
    logic acc_clr;
    logic rd_vld;
    logic rd_ok;
    logic load;
  } mac_ctrl_t;

  // datapath to sequencer status
  typedef struct packed {
    logic out_free;
  } mac_stat_t;

endpackage

// ===== sv/firch_ram.sv =====
// generic single write, single read ram with registered read data
// depends on nothing
module firch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/firch_seq.sv =====
// sequencer: input handshake, ring write slot, valid bits and tap walk
// depends on firch_pkg
module firch_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [firch_pkg::TSEL_W-1:0] tap_index_i,
  output logic                        tap_we_o,
  output logic [firch_pkg::IDX_W-1:0] tap_waddr_o,
  output logic                        hist_we_o,
  output logic [firch_pkg::IDX_W-1:0] hist_waddr_o,
  output logic                        rd_en_o,
  output logic [firch_pkg::IDX_W-1:0] tap_raddr_o,
  output logic [firch_pkg::IDX_W-1:0] hist_raddr_o,
  output firch_pkg::mac_ctrl_t        ctrl_o,
  input  firch_pkg::mac_stat_t        stat_i
);
  import firch_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(TAPS - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             drain_q, drain_d;
  logic [TAPS-1:0]  tap_vld_q, tap_vld_d;
  logic [TAPS-1:0]  hist_vld_q, hist_vld_d;
  logic             rd_vld_q, rd_ok_q, rd_ok_d;
  logic [IDX_W-1:0] slot_nxt;
  logic             accept;
  logic             tap_in_range;

  assign accept       = in_valid_i && (state_q == ST_IDLE);
  assign tap_in_range = int'(tap_index_i) < TAPS;
  assign slot_nxt     = (slot_q == LAST) ? '0 : slot_q + IDX_W'(1);

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slot_q     <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      drain_q    <= 1'b0;
      tap_vld_q  <= '0;
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_ok_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      drain_q    <= drain_d;
      tap_vld_q  <= tap_vld_d;
      hist_vld_q <= hist_vld_d;
      rd_vld_q   <= rd_en_o;
      rd_ok_q    <= rd_ok_d;
    end
  end

  // next state and outputs
  always_comb begin
    state_d        = state_q;
    slot_d         = slot_q;
    cnt_d          = cnt_q;
    idx_d          = idx_q;
    drain_d        = drain_q;
    tap_vld_d      = tap_vld_q;
    hist_vld_d     = hist_vld_q;
    rd_ok_d        = 1'b0;
    in_ready_o     = 1'b0;
    tap_we_o       = 1'b0;
    hist_we_o      = 1'b0;
    rd_en_o        = 1'b0;
    ctrl_o.acc_clr = 1'b0;
    ctrl_o.rd_vld  = rd_vld_q;
    ctrl_o.rd_ok   = rd_ok_q;
    ctrl_o.load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          if (op_i == OP_COEF) begin
            // coefficient word: write the tap if the index exists
            if (tap_in_range) begin
              tap_we_o                      = 1'b1;
              tap_vld_d[IDX_W'(tap_index_i)] = 1'b1;
            end
          end else begin
            // sample word: overwrite the oldest slot, walk from the new oldest
            hist_we_o          = 1'b1;
            hist_vld_d[slot_q] = 1'b1;
            slot_d             = slot_nxt;
            idx_d              = slot_nxt;
            cnt_d              = '0;
            ctrl_o.acc_clr     = 1'b1;
            state_d            = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        // one tap and one sample read per cycle
        rd_en_o = 1'b1;
        rd_ok_d = tap_vld_q[cnt_q] && hist_vld_q[idx_q];
        cnt_d   = cnt_q + IDX_W'(1);
        idx_d   = (idx_q == LAST) ? '0 : idx_q + IDX_W'(1);
        if (cnt_q == LAST) begin
          drain_d = 1'b0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the ram read register and the product register to empty
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (stat_i.out_free) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign tap_waddr_o   = IDX_W'(tap_index_i);
  assign hist_waddr_o  = slot_q;
  assign tap_raddr_o   = cnt_q;
  assign hist_raddr_o  = idx_q;

endmodule

// ===== sv/firch_mac.sv =====
// shared multiply-accumulate unit with rounding, saturation and result register
// depends on firch_pkg
module firch_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  firch_pkg::mac_ctrl_t                ctrl_i,
  output firch_pkg::mac_stat_t                stat_o,
  input  logic [firch_pkg::DATA_W-1:0]        tap_rd_i,
  input  logic [firch_pkg::DATA_W-1:0]        hist_rd_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [firch_pkg::DATA_W-1:0] sample_out_o,
  output logic                                clipped_o
);
  import firch_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1 << (FRAC_SH - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = -(ACC_W'(1 << (DATA_W - 1)));

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [DATA_W-1:0] sat_val;
  logic                     sat_clip;
  logic                     out_vld_q;
  logic signed [DATA_W-1:0] out_val_q;
  logic                     out_clip_q;

  // product register, zero for entries never written
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_vld) begin
      if (ctrl_i.rd_ok) begin
        prod_q <= $signed(tap_rd_i) * $signed(hist_rd_i);
      end else begin
        prod_q <= '0;
      end
    end
  end

  // accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.rd_vld;
      if (ctrl_i.acc_clr) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // round half up to the output grid, then saturate
  always_comb begin
    rnd      = (acc_q + RND_BIAS) >>> FRAC_SH;
    sat_clip = 1'b1;
    if (rnd > SAT_MAX) begin
      sat_val = SAT_MAX[DATA_W-1:0];
    end else if (rnd < SAT_MIN) begin
      sat_val = SAT_MIN[DATA_W-1:0];
    end else begin
      sat_val  = rnd[DATA_W-1:0];
      sat_clip = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl_i.load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      out_val_q  <= sat_val;
      out_clip_q <= sat_clip;
    end
  end

  assign stat_o.out_free = !out_vld_q || out_ready_i;
  assign out_valid_o     = out_vld_q;
  assign sample_out_o    = out_val_q;
  assign clipped_o       = out_clip_q;

endmodule

// ===== sv/fir_filter_circular_history_core.sv =====
// Direct-form FIR filter, 51 taps of Q1.15 over a ring of 16-bit samples.
// A coefficient word (op 1) writes one tap and gives no result; an index
// beyond the last tap is ignored. A sample word (op 0) overwrites the
// oldest sample and is accepted, then walks every tap through the shared
// multiply-accumulate unit, which reads one tap and one sample from the
// two RAMs each cycle, then empties the read and product registers, and
// then rounds and saturates. Tap 0 weights the oldest sample. The result
// register lets the next word in while a result waits; a second result
// waits in the round step until the first is taken. Taps and history read
// as zero until written.
module fir_filter_circular_history_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic signed [firch_pkg::DATA_W-1:0] sample_in_i,
  input  logic [firch_pkg::TSEL_W-1:0]        tap_index_i,
  input  logic signed [firch_pkg::DATA_W-1:0] tap_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [firch_pkg::DATA_W-1:0] sample_out_o,
  output logic                                clipped_o
);
  import firch_pkg::*;

  logic             tap_we, hist_we, rd_en;
  logic [IDX_W-1:0] tap_waddr, hist_waddr, tap_raddr, hist_raddr;
  logic [DATA_W-1:0] tap_rd, hist_rd;
  mac_ctrl_t        ctrl;
  mac_stat_t        stat;

  // sequencer
  firch_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .tap_index_i  (tap_index_i),
    .tap_we_o     (tap_we),
    .tap_waddr_o  (tap_waddr),
    .hist_we_o    (hist_we),
    .hist_waddr_o (hist_waddr),
    .rd_en_o      (rd_en),
    .tap_raddr_o  (tap_raddr),
    .hist_raddr_o (hist_raddr),
    .ctrl_o       (ctrl),
    .stat_i       (stat)
  );

  // coefficient store
  firch_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TAPS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (tap_waddr),
    .wdata_i (tap_value_i),
    .re_i    (rd_en),
    .raddr_i (tap_raddr),
    .rdata_o (tap_rd)
  );

  // sample history ring
  firch_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (sample_in_i),
    .re_i    (rd_en),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rd)
  );

  // shared multiply-accumulate and result stage
  firch_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .tap_rd_i     (tap_rd),
    .hist_rd_i    (hist_rd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

endmodule

// ===== sv/firch_checker.sv =====
// port-level checks for the circular history fir filter, bound to the top level
// depends on firch_pkg and fir_filter_circular_history_core_defines.svh
`include "fir_filter_circular_history_core_defines.svh"

module firch_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                op_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [firch_pkg::DATA_W-1:0] sample_out_o,
  input logic                                clipped_o
);
  import firch_pkg::*;

  logic in_acc, out_stall, clip_ok;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign clip_ok   = (sample_out_o == 16'sh7fff) || (sample_out_o == 16'sh8000);

  // a held result word keeps its value
  `FIRCH_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(sample_out_o) && $stable(clipped_o), "result word changed while stalled")

  // a sample word occupies the filter for the tap walk
  `FIRCH_ASSERT_NEXT(a_sample_busy, in_acc && (op_i == OP_FILTER), !in_ready_o, "ready right after a sample word")

  // a coefficient word leaves the filter ready in the next cycle
  `FIRCH_ASSERT_NEXT(a_coef_quick, in_acc && (op_i == OP_COEF), in_ready_o, "not ready after a coefficient word")

  // a clipped result sits on a rail
  `FIRCH_ASSERT_NOW(a_clip_rail, out_valid_o && clipped_o, clip_ok, "clipped result off the rails")

  // a new result only appears at the end of a tap walk
  `FIRCH_ASSERT_NOW(a_out_origin, $rose(out_valid_o), !$past(in_ready_o), "result without a sample word")

endmodule

bind fir_filter_circular_history_core firch_checker u_firch_checker (.*);

// ===== tb/fir_filter_circular_history_core_test.sv =====
`timescale 1ns / 1ps
// testbench for the 51-tap circular history fir filter core, self-checking
// depends on firch_pkg and fir_filter_circular_history_core
module fir_filter_circular_history_core_test;
  import firch_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 120;

  // one filtered output word
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              clip;
  } fir_out_t;

  // bit-true filter state and the outputs it still owes
  class fir_scoreboard;
    logic signed [DATA_W-1:0] ring [TAPS];
    logic signed [DATA_W-1:0] coefs [TAPS];
    int unsigned              next_slot;
    fir_out_t                 pending_samples [$];
    int unsigned              errors;
    int unsigned              results_seen;

    function new();
      foreach (ring[k]) begin
        ring[k]  = '0;
        coefs[k] = '0;
      end
      next_slot    = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    // apply one accepted input word to the filter state
    function void accept_word(op_e op, logic signed [DATA_W-1:0] smp,
                              logic [TSEL_W-1:0] tidx, logic signed [DATA_W-1:0] tval);
      longint      acc;
      longint      q;
      int unsigned rd;
      int          i;
      fir_out_t    res;
      if (op == OP_COEF) begin
        if (tidx < TAPS) coefs[tidx] = tval;
        return;
      end
      if (next_slot >= TAPS) next_slot = 0;
      ring[next_slot] = smp;
      next_slot++;
      if (next_slot >= TAPS) next_slot = 0;
      // tap 0 meets the oldest sample, which is the slot about to be overwritten
      acc = 0;
      rd  = next_slot;
      for (i = 0; i < TAPS; i++) begin
        acc += longint'(coefs[i]) * longint'(ring[rd]);
        rd++;
        if (rd >= TAPS) rd = 0;
      end
      // round half up to 15 fraction bits, then saturate
      q = (acc + 64'sd16384) >>> FRAC_SH;
      res.clip = 1'b0;
      if (q > 32767) begin
        q = 32767;
        res.clip = 1'b1;
      end else if (q < -32768) begin
        q = -32768;
        res.clip = 1'b1;
      end
      res.value = q[DATA_W-1:0];
      pending_samples.push_back(res);
    endfunction

    // compare one output word with the oldest pending one
    function void check_output(logic [DATA_W-1:0] got_value, logic got_clip);
      fir_out_t want;
      results_seen++;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got sample_out %0d clipped %0b",
                 $time, $signed(got_value), got_clip);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      if (got_value !== want.value) begin
        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                 $time, $signed(want.value), $signed(got_value));
        errors++;
      end
      if (got_clip !== want.clip) begin
        $display("%0t: clipped mismatch, expected %0b, got %0b", $time, want.clip, got_clip);
        errors++;
      end
    endfunction

    function int pending_count();
      return pending_samples.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     op = 1'b0;
  logic signed [DATA_W-1:0] sample_in = '0;
  logic [TSEL_W-1:0]        tap_index = '0;
  logic signed [DATA_W-1:0] tap_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] sample_out;
  logic                     clipped;

  fir_scoreboard sb = new();
  int unsigned   burst_left = 0;

  fir_filter_circular_history_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .sample_in_i  (sample_in),
    .tap_index_i  (tap_index),
    .tap_value_i  (tap_value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out),
    .clipped_o    (clipped)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // signed value spread evenly over -mag..mag
  function automatic logic [DATA_W-1:0] rand_signed(int mag);
    int v;
    v = int'($urandom_range(0, 2 * mag)) - mag;
    return v[DATA_W-1:0];
  endfunction

  // mix of extremes, full-range and modest values
  function automatic logic [DATA_W-1:0] pick_value(int mag);
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return DATA_W'($urandom);
      default: return rand_signed(mag);
    endcase
  endfunction

  // offer one word in bursts with random gaps, wait for acceptance
  task automatic send_word(op_e code, logic [DATA_W-1:0] smp, logic [TSEL_W-1:0] tidx,
                           logic [DATA_W-1:0] tval);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    op        <= code;
    sample_in <= smp;
    tap_index <= tidx;
    tap_value <= tval;
    do @(posedge clk); while (!in_ready);
    sb.accept_word(code, smp, tidx, tval);
  endtask

  // unused fields carry random junk
  task automatic put_sample(logic [DATA_W-1:0] smp);
    send_word(OP_FILTER, smp, TSEL_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic put_tap(logic [TSEL_W-1:0] tidx, logic [DATA_W-1:0] tval);
    send_word(OP_COEF, DATA_W'($urandom), tidx, tval);
  endtask

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(sample_out, clipped);
  end

  // receiver: stall pattern in spans, one long hold-off to back the block up
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk);
        if (!held && sb.results_seen >= 120) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // stimulus
  initial begin
    int phase;
    int t;
    int n;
    logic [DATA_W-1:0] v;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // cleared taps give zero
    put_sample(16'h7FFF);
    // single tap on the newest sample acts as a bypass
    put_tap(TSEL_W'(TAPS - 1), 16'h7FFF);
    put_sample(16'h7FFF);
    put_sample(16'h8000);
    // minus one times the most negative sample saturates high
    put_tap(TSEL_W'(TAPS - 1), 16'h8000);
    put_sample(16'h8000);
    put_sample(16'h7FFF);
    // half weight: ties round toward plus infinity
    put_tap(TSEL_W'(TAPS - 1), 16'h4000);
    put_sample(16'h0001);
    put_sample(16'hFFFF);
    put_sample(16'h0003);
    put_sample(16'hFFFD);
    // tap indexes past the last tap are dropped
    put_tap(6'd63, 16'h7FFF);
    put_tap(TSEL_W'(TAPS), 16'h7FFF);
    put_sample(16'h0005);
    // three full negative taps, oldest included: clip both ways
    put_tap(TSEL_W'(0), 16'h8000);
    put_tap(TSEL_W'(TAPS - 2), 16'h8000);
    put_tap(TSEL_W'(TAPS - 1), 16'h8000);
    put_sample(16'h7FFF);
    put_sample(16'h7FFF);
    put_sample(16'h8000);
    put_sample(16'h8000);

    // random phases: reload the whole tap set, then mixed traffic
    for (phase = 0; phase < 4; phase++) begin
      for (t = 0; t < TAPS; t++) begin
        case (phase)
          0:       v = rand_signed(1200);
          1:       v = DATA_W'($urandom);
          2:       v = (t == TAPS - 1) ? DATA_W'($urandom) : '0;
          default: v = pick_value(800);
        endcase
        put_tap(TSEL_W'(t), v);
      end
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 6) == 0) begin
            put_tap(TSEL_W'($urandom_range(TAPS, 63)), DATA_W'($urandom));
          end else begin
            put_tap(TSEL_W'($urandom_range(0, TAPS - 1)), pick_value(1500));
          end
        end else begin
          put_sample(pick_value(4000));
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then watch for stray output words
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (TAPS + 20) @(posedge clk);

    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
